// ===== rtl/core/ssmf_pkg.sv =====
// Shared types, constants and the sample scaling function of the scaled
// sliding median filter. No dependencies.
`timescale 1ns / 1ps

package ssmf_pkg;

  localparam int RAW_W    = 10;
  localparam int VAL_W    = 7;
  localparam int RAW_FULL = 1023;
  localparam int VAL_FULL = 127;
  localparam int PROD_W   = 17;

  typedef struct packed {
    logic load;
    logic rot;
  } rank_ctrl_t;

  // raw * 127 / 1023: the quotient by 1024 is low by at most one, and the
  // remainder against 1023 stays below twice 1023, so one compare fixes it.
  function automatic logic [VAL_W-1:0] scale_sample(input logic [RAW_W-1:0] raw);
    logic [PROD_W-1:0] prod;
    logic [VAL_W-1:0]  q0;
    logic [PROD_W-1:0] rem;
    prod = PROD_W'(raw) * PROD_W'(VAL_FULL);
    q0   = prod[PROD_W-1:RAW_W];
    rem  = prod - (PROD_W'(q0) << RAW_W) + PROD_W'(q0);
    return (rem >= PROD_W'(RAW_FULL)) ? q0 + 1'b1 : q0;
  endfunction

endpackage

// ===== rtl/core/ssmf_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ssmf_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 5,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ssmf_rank.sv =====
// Rank unit: a rotating copy of the window; each rotate cycle the head is
// ranked against all entries and kept when it sits at the median position.
// Depends on ssmf_pkg.
`timescale 1ns / 1ps

module ssmf_rank import ssmf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  rank_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] din,
  output logic [VAL_W-1:0] median
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int K     = (WINDOW + 1) / 2 - 1;

  logic [VAL_W-1:0] taps [WINDOW];
  logic [CNT_W-1:0] less_cnt;
  logic [CNT_W-1:0] leq_cnt;
  logic             hit;

  always_comb begin
    less_cnt = '0;
    leq_cnt  = '0;
    for (int j = 0; j < WINDOW; j++) begin
      less_cnt = less_cnt + CNT_W'(taps[j] < taps[0]);
      leq_cnt  = leq_cnt + CNT_W'(taps[j] <= taps[0]);
    end
    hit = (less_cnt <= CNT_W'(K)) && (leq_cnt > CNT_W'(K));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int j = 0; j < WINDOW - 1; j++) begin
        taps[j] <= taps[j+1];
      end
      taps[WINDOW-1] <= din;
    end else if (ctrl.rot) begin
      for (int j = 0; j < WINDOW - 1; j++) begin
        taps[j] <= taps[j+1];
      end
      taps[WINDOW-1] <= taps[0];
    end
    if (rst) begin
      median <= '0;
    end else if (ctrl.rot && hit) begin
      median <= taps[0];
    end
  end

endmodule

// ===== rtl/core/scaled_sliding_median_filter.sv =====
// Top level of the scaled sliding median filter: sequencer, window memory
// and rank unit. Depends on ssmf_pkg, ssmf_ram and ssmf_rank.
//
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_ready  raw_sample[9:0]
// output   out        out_valid/ out_ready median_value[6:0], value_changed
//
// From acceptance to a valid result: S_LOAD makes WINDOW memory reads
// that copy the window into the rank unit, S_FILL lands the last read,
// S_RANK rotates the window once through to find the median, and S_DONE
// loads the output register. The next item is accepted back in S_IDLE.
// The window memory starts as all zero through per-slot valid bits that
// reset clears, so no clearing pass is needed.
// A new item is accepted while a result waits; a finished item then holds
// until the output register is free.
`timescale 1ns / 1ps

module scaled_sliding_median_filter import ssmf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] raw_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] median_value,
  output logic             value_changed
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FILL,
    S_RANK,
    S_DONE
  } state_t;

  state_t            state;
  logic [VAL_W-1:0]  scaled;
  logic [AW-1:0]     wr_slot;
  logic [WINDOW-1:0] slot_valid;
  logic [AW-1:0]     cnt;
  logic              rd_pend;
  logic              rd_fwd;
  logic              rd_vld;
  logic [VAL_W-1:0]  last_median;
  logic              we;
  logic [VAL_W-1:0]  rdata;
  logic [VAL_W-1:0]  rank_din;
  logic [VAL_W-1:0]  rank_median;
  rank_ctrl_t        ctrl;

  assign in_ready = (state == S_IDLE);
  assign we       = (state == S_LOAD) && (cnt == '0);
  assign rank_din = rd_fwd ? scaled : (rd_vld ? rdata : '0);
  assign ctrl.load = rd_pend;
  assign ctrl.rot  = (state == S_RANK);

  ssmf_ram #(
    .WIDTH (VAL_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (we),
    .waddr (wr_slot),
    .wdata (scaled),
    .raddr (cnt),
    .rdata (rdata)
  );

  ssmf_rank #(
    .WINDOW (WINDOW)
  ) u_rank (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .din    (rank_din),
    .median (rank_median)
  );

  always_ff @(posedge clk) begin
    rd_fwd <= we && (cnt == wr_slot);
    rd_vld <= slot_valid[cnt];
    if (rst) begin
      state        <= S_IDLE;
      wr_slot      <= '0;
      slot_valid   <= '0;
      cnt          <= '0;
      rd_pend      <= 1'b0;
      last_median  <= '0;
      out_valid    <= 1'b0;
      median_value <= '0;
      value_changed <= 1'b0;
    end else begin
      rd_pend <= (state == S_LOAD);
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            scaled <= scale_sample(raw_sample);
            cnt    <= '0;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (we) begin
            slot_valid[wr_slot] <= 1'b1;
            wr_slot <= (wr_slot == AW'(WINDOW - 1)) ? '0 : wr_slot + 1'b1;
          end
          if (cnt == AW'(WINDOW - 1)) begin
            cnt   <= '0;
            state <= S_FILL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FILL: begin
          state <= S_RANK;
        end
        S_RANK: begin
          if (cnt == AW'(WINDOW - 1)) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            median_value  <= rank_median;
            value_changed <= (rank_median != last_median);
            last_median   <= rank_median;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    wr_slot <= AW'(WINDOW - 1))
    else $error("write slot out of range");

  a_out_tracks_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (median_value == last_median))
    else $error("shown median differs from stored previous median");

  a_window_written: assert property (@(posedge clk) disable iff (rst)
    (state == S_RANK) |-> ($countones(slot_valid) != 0))
    else $error("ranking with no written slot");
`endif

endmodule
